>>> rtl/assert_macros.svh
// Assertion helpers shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Types and codes shared by the sorted item table modules.
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_SORT   = 3'd2;
   localparam logic [2:0] CMD_SEARCH = 3'd3;
   localparam logic [2:0] CMD_LIST   = 3'd4;

   localparam logic [2:0] KEY_NAME   = 3'd1;
   localparam logic [2:0] KEY_KIND   = 3'd2;
   localparam logic [2:0] KEY_AMOUNT = 3'd3;
   localparam logic [2:0] KEY_RANK   = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_NOT_SORTED = 3'd4;
   localparam logic [2:0] ST_BAD_KEY   = 3'd5;

   typedef struct packed {
      logic [63:0] name_hi;
      logic [63:0] name_lo;
      logic [63:0] kind_hi;
      logic [63:0] kind_lo;
      logic [15:0] amount;
      logic [2:0]  rank;
   } record_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [2:0]  sort_key;
      logic [63:0] name_hi;
      logic [63:0] name_lo;
      logic [63:0] kind_hi;
      logic [63:0] kind_lo;
      logic [15:0] amount;
      logic [2:0]  rank;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  entries;
      logic [63:0] out_name_hi;
      logic [63:0] out_name_lo;
      logic [63:0] out_kind_hi;
      logic [63:0] out_kind_lo;
      logic [15:0] out_amount;
      logic [2:0]  out_rank;
      logic        last;
   } rsp_type;

   // true when record a must move after record b under the key
   function automatic logic out_of_order(logic [2:0] key, record_type a, record_type b);
      logic r;
      case (key)
         KEY_NAME: r = {a.name_hi, a.name_lo} > {b.name_hi, b.name_lo};
         KEY_KIND: r = {a.kind_hi, a.kind_lo} > {b.kind_hi, b.kind_lo};
         KEY_AMOUNT: r = a.amount > b.amount;
         default: r = a.rank > b.rank;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
   parameter int Depth = 16,
   parameter int AddrWidth = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AddrWidth-1:0]   wr_addr,
   input  sit_pkg::record_type    wr_data,
   input  logic [AddrWidth-1:0]   rd_addr,
   output sit_pkg::record_type    rd_data
);

   sit_pkg::record_type mem [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/sorted_item_table_core.sv
// ----------------------------------------------------------------------------
// sorted_item_table_core
// Record table with add, remove, stable sort, binary search and list.
// ----------------------------------------------------------------------------
// Commands enter with start while busy is low; results come out on rsp_valid
// for one cycle each and cannot be held off. All records sit in one
// single-port-read memory, so every step is a read and a registered
// compare. Add passes through the read and done states, an error answer
// goes straight to done. Remove scans entries until a match, then moves each
// later entry down; search probes the table by binary search, list reads
// every entry in order, and a sort makes passes over the table that compare
// and swap neighbouring records. busy stays high throughout.
module sorted_item_table_core #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sit_pkg::req_type   req_item,
   output logic               rsp_valid,
   output sit_pkg::rsp_type   rsp_item
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_RD    = 10'b0000000010,
      S_WAIT  = 10'b0000000100,
      S_EVAL  = 10'b0000001000,
      S_RD2   = 10'b0000010000,
      S_WAIT2 = 10'b0000100000,
      S_CMP2  = 10'b0001000000,
      S_SWAP  = 10'b0010000000,
      S_SHIFT = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   sit_pkg::req_type    req_ff, req_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                sorted_ff, sorted_in;
   logic [CW-1:0]       i_ff, i_in, j_ff, j_in;
   logic [CW:0]         lo_ff, lo_in, hi_ff, hi_in;
   sit_pkg::record_type held_ff, held_in;
   logic                rv_ff, rv_in;
   sit_pkg::rsp_type    rsp_ff, rsp_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   sit_pkg::record_type wr_data, rd_data;
   logic [CW:0]         mid;

   sit_ram #(.Depth(CAPACITY), .AddrWidth(AW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_item  = rsp_ff;
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);

   function automatic sit_pkg::rsp_type mk(logic [2:0] st, logic [CW-1:0] n,
                                            sit_pkg::record_type r, logic lst);
      sit_pkg::rsp_type o;
      o.status      = st;
      o.entries     = 5'(n);
      o.out_name_hi = r.name_hi;
      o.out_name_lo = r.name_lo;
      o.out_kind_hi = r.kind_hi;
      o.out_kind_lo = r.kind_lo;
      o.out_amount  = r.amount;
      o.out_rank    = r.rank;
      o.last        = lst;
      return o;
   endfunction

   // sequence one command over the memory
   always_comb begin
      sit_pkg::record_type zero_rec;
      sit_pkg::record_type new_rec;
      zero_rec = '0;
      new_rec = '{req_ff.name_hi, req_ff.name_lo, req_ff.kind_hi, req_ff.kind_lo,
                  req_ff.amount, req_ff.rank};
      state_in = state_ff;
      req_in = req_ff;
      count_in = count_ff;
      sorted_in = sorted_ff;
      i_in = i_ff;
      j_in = j_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      held_in = held_ff;
      rv_in = 1'b0;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = AW'(j_ff);
      wr_data = rd_data;
      rd_addr = AW'(j_ff);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               i_in = '0;
               j_in = '0;
               lo_in = '0;
               hi_in = (CW+1)'(count_ff) - 1'b1;
               state_in = S_RD;
               if (req_item.command > sit_pkg::CMD_LIST) begin
                  state_in = S_IDLE;
               end else if (req_item.command == sit_pkg::CMD_ADD) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rv_in = 1'b1;
                     rsp_in = mk(sit_pkg::ST_FULL, count_ff, zero_rec, 1'b1);
                     state_in = S_DONE;
                  end
               end else if (count_ff == '0) begin
                  rv_in = 1'b1;
                  rsp_in = mk(sit_pkg::ST_EMPTY, count_ff, zero_rec, 1'b1);
                  state_in = S_DONE;
               end else if (req_item.command == sit_pkg::CMD_SORT) begin
                  sorted_in = 1'b0;
                  if (req_item.sort_key < sit_pkg::KEY_NAME ||
                      req_item.sort_key > sit_pkg::KEY_RANK) begin
                     rv_in = 1'b1;
                     rsp_in = mk(sit_pkg::ST_BAD_KEY, count_ff, zero_rec, 1'b1);
                     state_in = S_DONE;
                  end
               end else if (req_item.command == sit_pkg::CMD_SEARCH && !sorted_ff) begin
                  rv_in = 1'b1;
                  rsp_in = mk(sit_pkg::ST_NOT_SORTED, count_ff, zero_rec, 1'b1);
                  state_in = S_DONE;
               end
            end
         end
         S_RD: begin
            // issue read of the current entry
            rd_addr = (req_ff.command == sit_pkg::CMD_SEARCH) ? AW'(mid) : AW'(j_ff);
            case (req_ff.command)
               sit_pkg::CMD_ADD: begin
                  wr_en = 1'b1;
                  wr_addr = AW'(count_ff);
                  wr_data = new_rec;
                  count_in = count_ff + 1'b1;
                  sorted_in = 1'b0;
                  rv_in = 1'b1;
                  rsp_in = mk(sit_pkg::ST_OK, count_ff + 1'b1, new_rec, 1'b1);
                  state_in = S_DONE;
               end
               sit_pkg::CMD_SORT: begin
                  if (CW'(i_ff + 1'b1) >= count_ff) begin
                     if (req_ff.sort_key == sit_pkg::KEY_NAME) sorted_in = 1'b1;
                     rv_in = 1'b1;
                     rsp_in = mk(sit_pkg::ST_OK, count_ff, zero_rec, 1'b1);
                     state_in = S_DONE;
                  end else if (CW'(j_ff + 1'b1) >= CW'(count_ff - i_ff)) begin
                     i_in = i_ff + 1'b1;
                     j_in = '0;
                  end else begin
                     state_in = S_WAIT;
                  end
               end
               default: state_in = S_WAIT;
            endcase
         end
         S_WAIT: begin
            // keep the same address so the read data stays on that entry
            rd_addr = (req_ff.command == sit_pkg::CMD_SEARCH) ? AW'(mid) : AW'(j_ff);
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (req_ff.command)
               sit_pkg::CMD_REMOVE: begin
                  if ({rd_data.name_hi, rd_data.name_lo} ==
                      {req_ff.name_hi, req_ff.name_lo}) begin
                     rv_in = 1'b1;
                     rsp_in = mk(sit_pkg::ST_OK, count_ff - 1'b1, rd_data, 1'b1);
                     state_in = S_SHIFT;
                  end else if (j_ff + 1'b1 == count_ff) begin
                     rv_in = 1'b1;
                     rsp_in = mk(sit_pkg::ST_NOT_FOUND, count_ff, zero_rec, 1'b1);
                     state_in = S_DONE;
                  end else begin
                     j_in = j_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               sit_pkg::CMD_SEARCH: begin
                  if ({rd_data.name_hi, rd_data.name_lo} ==
                      {req_ff.name_hi, req_ff.name_lo}) begin
                     rv_in = 1'b1;
                     rsp_in = mk(sit_pkg::ST_OK, count_ff, rd_data, 1'b1);
                     state_in = S_DONE;
                  end else begin
                     if ({rd_data.name_hi, rd_data.name_lo} <
                         {req_ff.name_hi, req_ff.name_lo}) begin
                        lo_in = mid + 1'b1;
                     end else begin
                        hi_in = mid - 1'b1;
                     end
                     if ((lo_in[CW] == 1'b0 && hi_in[CW] == 1'b0 && lo_in <= hi_in)) begin
                        state_in = S_RD;
                     end else begin
                        rv_in = 1'b1;
                        rsp_in = mk(sit_pkg::ST_NOT_FOUND, count_ff, zero_rec, 1'b1);
                        state_in = S_DONE;
                     end
                  end
               end
               sit_pkg::CMD_LIST: begin
                  rv_in = 1'b1;
                  rsp_in = mk(sit_pkg::ST_OK, count_ff, rd_data,
                              j_ff + 1'b1 == count_ff);
                  if (j_ff + 1'b1 == count_ff) begin
                     state_in = S_DONE;
                  end else begin
                     j_in = j_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               default: begin
                  // sort: hold entry j, fetch j+1
                  held_in = rd_data;
                  state_in = S_RD2;
               end
            endcase
         end
         S_RD2: begin
            rd_addr = AW'(j_ff + 1'b1);
            state_in = S_WAIT2;
         end
         S_WAIT2: begin
            // keep reading entry j+1
            rd_addr = AW'(j_ff + 1'b1);
            state_in = S_CMP2;
         end
         S_CMP2: begin
            if (sit_pkg::out_of_order(req_ff.sort_key, held_ff, rd_data)) begin
               wr_en = 1'b1;
               wr_addr = AW'(j_ff);
               wr_data = rd_data;
               state_in = S_SWAP;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_SWAP: begin
            wr_en = 1'b1;
            wr_addr = AW'(j_ff + 1'b1);
            wr_data = held_ff;
            j_in = j_ff + 1'b1;
            state_in = S_RD;
         end
         S_SHIFT: begin
            // copy entry j+1 down to j, one read then one write
            if (j_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               sorted_in = 1'b0;
               state_in = S_DONE;
            end else begin
               rd_addr = AW'(j_ff + 1'b1);
               state_in = S_WAIT2;
               req_in.command = sit_pkg::CMD_LIST + 3'd1;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // shift write-back path reuses the wait and compare states
      if (state_ff == S_CMP2 && req_ff.command == sit_pkg::CMD_LIST + 3'd1) begin
         wr_en = 1'b1;
         wr_addr = AW'(j_ff);
         wr_data = rd_data;
         j_in = j_ff + 1'b1;
         state_in = S_SHIFT;
      end
   end

   // advance control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         sorted_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sorted_ff <= sorted_in;
         rv_ff     <= rv_in;
      end
      req_ff  <= req_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
   end

endmodule

>>> rtl/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks on the command and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sit_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input sit_pkg::rsp_type rsp_item
);

   `CHK_IMPL(a_entries_range, clock, reset, rsp_valid, rsp_item.entries <= 5'd16, "entries too large")
   `CHK_IMPL(a_status_range, clock, reset, rsp_valid, rsp_item.status <= sit_pkg::ST_BAD_KEY, "bad status")
   `CHK_NEXT(a_busy_after_start, clock, reset, start && !busy && !rsp_valid, busy || !rsp_valid, "no busy")
   `CHK_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_item.status != sit_pkg::ST_OK, rsp_item.out_amount == 16'd0 && rsp_item.last, "error record not zero")

endmodule

bind sorted_item_table_core sit_checker u_sit_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_item (rsp_item)
);

>>> tb/sorted_item_table_checker.sv
// ----------------------------------------------------------------------------
// sorted_item_table_checker
// Watches the command and result channels of the sorted item table, keeps a
// shadow copy of the table, predicts every result and compares field by field.
// ----------------------------------------------------------------------------
module sorted_item_table_checker #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  sit_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  sit_pkg::rsp_type rsp_item,
   output int               fail_count,
   output int               pending
);

   sit_pkg::record_type table_q[$];
   logic                name_ordered;
   sit_pkg::rsp_type    expected_q[$];

   function automatic sit_pkg::rsp_type make_rsp(logic [2:0] status,
                                                 sit_pkg::record_type rec, logic last);
      sit_pkg::rsp_type r;
      r.status      = status;
      r.entries     = 5'(table_q.size());
      r.out_name_hi = rec.name_hi;
      r.out_name_lo = rec.name_lo;
      r.out_kind_hi = rec.kind_hi;
      r.out_kind_lo = rec.kind_lo;
      r.out_amount  = rec.amount;
      r.out_rank    = rec.rank;
      r.last        = last;
      return r;
   endfunction

   function automatic logic must_follow(logic [2:0] key, sit_pkg::record_type a,
                                        sit_pkg::record_type b);
      case (key)
         sit_pkg::KEY_NAME:   return {a.name_hi, a.name_lo} > {b.name_hi, b.name_lo};
         sit_pkg::KEY_KIND:   return {a.kind_hi, a.kind_lo} > {b.kind_hi, b.kind_lo};
         sit_pkg::KEY_AMOUNT: return a.amount > b.amount;
         default:             return a.rank > b.rank;
      endcase
   endfunction

   // apply one command to the shadow table and queue its results
   task automatic predict_command(sit_pkg::req_type c);
      sit_pkg::record_type rec, blank, tmp;
      int n, lo, hi, mid, hit;
      blank = '0;
      n = table_q.size();
      if (c.command > sit_pkg::CMD_LIST) return;
      if (c.command == sit_pkg::CMD_ADD) begin
         if (n >= CAPACITY) begin
            expected_q.push_back(make_rsp(sit_pkg::ST_FULL, blank, 1'b1));
            return;
         end
         rec = '{c.name_hi, c.name_lo, c.kind_hi, c.kind_lo, c.amount, c.rank};
         table_q.push_back(rec);
         name_ordered = 1'b0;
         expected_q.push_back(make_rsp(sit_pkg::ST_OK, rec, 1'b1));
         return;
      end
      if (n == 0) begin
         expected_q.push_back(make_rsp(sit_pkg::ST_EMPTY, blank, 1'b1));
         return;
      end
      case (c.command)
         sit_pkg::CMD_REMOVE: begin
            hit = -1;
            for (int i = 0; i < n && hit < 0; i++)
               if ({table_q[i].name_hi, table_q[i].name_lo} == {c.name_hi, c.name_lo})
                  hit = i;
            if (hit < 0) begin
               expected_q.push_back(make_rsp(sit_pkg::ST_NOT_FOUND, blank, 1'b1));
            end else begin
               rec = table_q[hit];
               table_q.delete(hit);
               name_ordered = 1'b0;
               expected_q.push_back(make_rsp(sit_pkg::ST_OK, rec, 1'b1));
            end
         end
         sit_pkg::CMD_SORT: begin
            name_ordered = 1'b0;
            if (c.sort_key < sit_pkg::KEY_NAME || c.sort_key > sit_pkg::KEY_RANK) begin
               expected_q.push_back(make_rsp(sit_pkg::ST_BAD_KEY, blank, 1'b1));
            end else begin
               for (int i = 0; i + 1 < n; i++)
                  for (int j = 0; j + 1 < n - i; j++)
                     if (must_follow(c.sort_key, table_q[j], table_q[j+1])) begin
                        tmp = table_q[j];
                        table_q[j] = table_q[j+1];
                        table_q[j+1] = tmp;
                     end
               if (c.sort_key == sit_pkg::KEY_NAME) name_ordered = 1'b1;
               expected_q.push_back(make_rsp(sit_pkg::ST_OK, blank, 1'b1));
            end
         end
         sit_pkg::CMD_SEARCH: begin
            if (!name_ordered) begin
               expected_q.push_back(make_rsp(sit_pkg::ST_NOT_SORTED, blank, 1'b1));
            end else begin
               lo = 0;
               hi = n - 1;
               hit = -1;
               while (lo <= hi && hit < 0) begin
                  mid = lo + (hi - lo) / 2;
                  if ({table_q[mid].name_hi, table_q[mid].name_lo} == {c.name_hi, c.name_lo})
                     hit = mid;
                  else if ({table_q[mid].name_hi, table_q[mid].name_lo}
                           < {c.name_hi, c.name_lo})
                     lo = mid + 1;
                  else
                     hi = mid - 1;
               end
               if (hit < 0)
                  expected_q.push_back(make_rsp(sit_pkg::ST_NOT_FOUND, blank, 1'b1));
               else
                  expected_q.push_back(make_rsp(sit_pkg::ST_OK, table_q[hit], 1'b1));
            end
         end
         default: begin
            for (int i = 0; i < n; i++)
               expected_q.push_back(make_rsp(sit_pkg::ST_OK, table_q[i], i + 1 == n));
         end
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // compare a result transfer with the oldest expectation
   task automatic check_result(sit_pkg::rsp_type got);
      sit_pkg::rsp_type w;
      if (expected_q.size() == 0) begin
         report_mismatch("unexpected result", 64'd1, 64'd0);
         return;
      end
      w = expected_q.pop_front();
      if (got.status !== w.status) report_mismatch("status", got.status, w.status);
      if (got.entries !== w.entries) report_mismatch("entries", got.entries, w.entries);
      if (got.out_name_hi !== w.out_name_hi)
         report_mismatch("name_hi", got.out_name_hi, w.out_name_hi);
      if (got.out_name_lo !== w.out_name_lo)
         report_mismatch("name_lo", got.out_name_lo, w.out_name_lo);
      if (got.out_kind_hi !== w.out_kind_hi)
         report_mismatch("kind_hi", got.out_kind_hi, w.out_kind_hi);
      if (got.out_kind_lo !== w.out_kind_lo)
         report_mismatch("kind_lo", got.out_kind_lo, w.out_kind_lo);
      if (got.out_amount !== w.out_amount)
         report_mismatch("amount", got.out_amount, w.out_amount);
      if (got.out_rank !== w.out_rank) report_mismatch("rank", got.out_rank, w.out_rank);
      if (got.last !== w.last) report_mismatch("last", got.last, w.last);
   endtask

   // results before commands: a result never belongs to a command of this edge
   always @(posedge clock) begin
      if (reset) begin
         table_q.delete();
         expected_q.delete();
         name_ordered = 1'b0;
         fail_count = 0;
      end else begin
         if (rsp_valid) check_result(rsp_item);
         if (start && !busy) predict_command(req_item);
      end
      pending = expected_q.size();
   end

endmodule

>>> tb/tb_sorted_item_table_core.sv
// ----------------------------------------------------------------------------
// tb_sorted_item_table_core
// Drives directed and random table commands into the sorted item table and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_sorted_item_table_core;

   localparam int CAPACITY = 16;
   localparam int STALL_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   sit_pkg::req_type req_item = '0;
   logic             rsp_valid;
   sit_pkg::rsp_type rsp_item;
   int               fail_count;
   int               pending;
   int               idle_pct = 0;
   int               quiet_cycles = 0;
   logic [63:0]      name_pool [8];

   sorted_item_table_core #(.CAPACITY(CAPACITY)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   sorted_item_table_checker #(.CAPACITY(CAPACITY)) checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .fail_count(fail_count),
      .pending(pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL sorted_item_table_core");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // send one command; random gap first, start held until the transfer
   task automatic issue(sit_pkg::req_type c);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item <= c;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic issue_cmd(logic [2:0] op, logic [2:0] key, logic [63:0] nh, logic [63:0] nl);
      sit_pkg::req_type c;
      c = '{op, key, nh, nl, rand64(), rand64(), 16'($urandom()), 3'($urandom())};
      issue(c);
   endtask

   // mostly small pool names so remove and search hit often
   task automatic random_command();
      logic [63:0] nh, nl;
      int pick;
      logic [2:0] op;
      pick = $urandom_range(99);
      if (pick < 35) op = sit_pkg::CMD_ADD;
      else if (pick < 50) op = sit_pkg::CMD_REMOVE;
      else if (pick < 70) op = sit_pkg::CMD_SORT;
      else if (pick < 85) op = sit_pkg::CMD_SEARCH;
      else if (pick < 97) op = sit_pkg::CMD_LIST;
      else op = 3'($urandom_range(7, 5));
      if ($urandom_range(9) < 7) begin
         nh = name_pool[$urandom_range(7)];
         nl = '0;
      end else begin
         nh = rand64();
         nl = rand64();
      end
      if ($urandom_range(9) < 8) issue_cmd(op, 3'($urandom_range(4, 1)), nh, nl);
      else issue_cmd(op, 3'($urandom()), nh, nl);
   endtask

   initial begin
      for (int i = 0; i < 8; i++) name_pool[i] = rand64();
      name_pool[0] = '0;
      name_pool[1] = '1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table errors, extremes, full table, every sort key
      issue_cmd(sit_pkg::CMD_REMOVE, sit_pkg::KEY_NAME, '0, '0);
      issue_cmd(sit_pkg::CMD_SORT, sit_pkg::KEY_NAME, '0, '0);
      issue_cmd(sit_pkg::CMD_SEARCH, sit_pkg::KEY_NAME, '0, '0);
      issue_cmd(sit_pkg::CMD_LIST, sit_pkg::KEY_NAME, '0, '0);
      issue('{sit_pkg::CMD_ADD, 3'd7, '1, '1, '1, '1, 16'hffff, 3'd7});
      issue('{sit_pkg::CMD_ADD, 3'd0, '0, '0, '0, '0, 16'h0000, 3'd0});
      issue_cmd(sit_pkg::CMD_SEARCH, sit_pkg::KEY_NAME, '1, '1);
      for (int i = 0; i < CAPACITY - 1; i++)
         issue_cmd(sit_pkg::CMD_ADD, sit_pkg::KEY_NAME, rand64(), rand64());
      issue_cmd(sit_pkg::CMD_SORT, 3'd0, '0, '0);
      issue_cmd(sit_pkg::CMD_SORT, 3'd5, '0, '0);
      issue_cmd(sit_pkg::CMD_SORT, sit_pkg::KEY_KIND, '0, '0);
      issue_cmd(sit_pkg::CMD_SORT, sit_pkg::KEY_AMOUNT, '0, '0);
      issue_cmd(sit_pkg::CMD_SORT, sit_pkg::KEY_RANK, '0, '0);
      issue_cmd(sit_pkg::CMD_SORT, sit_pkg::KEY_NAME, '0, '0);
      issue_cmd(sit_pkg::CMD_SEARCH, sit_pkg::KEY_NAME, '1, '1);
      issue_cmd(sit_pkg::CMD_SEARCH, sit_pkg::KEY_NAME, '0, '0);
      issue_cmd(sit_pkg::CMD_SEARCH, sit_pkg::KEY_NAME, 64'h1, '0);
      issue_cmd(sit_pkg::CMD_LIST, sit_pkg::KEY_NAME, '0, '0);
      issue_cmd(sit_pkg::CMD_REMOVE, sit_pkg::KEY_NAME, '1, '1);
      issue_cmd(sit_pkg::CMD_REMOVE, sit_pkg::KEY_NAME, 64'h1, '0);
      issue_cmd(3'd6, sit_pkg::KEY_NAME, '0, '0);

      // hold off until the table has answered everything
      start <= 1'b0;
      while (pending != 0) @(negedge clock);

      // random phases: sender idles lightly, then more often, then sends back to back
      idle_pct = 24;
      repeat (82) random_command();
      idle_pct = 46;
      repeat (82) random_command();
      idle_pct = 0;
      repeat (82) random_command();

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (600) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS sorted_item_table_core");
      end else begin
         $display("FAIL sorted_item_table_core");
      end
      $finish;
   end

endmodule
